[design/rpn_pkg.sv]
// rpn_pkg: shared types and constants for the postfix expression evaluator
// used by rpn_front, rpn_queue, rpn_back and the top level
package rpn_pkg;

	localparam int DefStackDepth = 64;
	localparam int QueueDepth    = 4;

	localparam logic [7:0] ChPlus  = 8'h2b;
	localparam logic [7:0] ChMinus = 8'h2d;
	localparam logic [7:0] ChStar  = 8'h2a;
	localparam logic [7:0] ChSlash = 8'h2f;
	localparam logic [7:0] ChCaret = 8'h5e;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;

	localparam logic [1:0] StOk    = 2'd0;
	localparam logic [1:0] StUnder = 2'd1;
	localparam logic [1:0] StOver  = 2'd2;
	localparam logic [1:0] StDivz  = 2'd3;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_NUM  = 2'd1,
		CMD_OP   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] data;
		logic        expr_end;
	} cmd_t;

endpackage

[design/rpn_front.sv]
// rpn_front: takes characters, builds decimal numbers and classifies tokens
// depends on rpn_pkg; feeds commands to rpn_queue
module rpn_front import rpn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       token_last,
	input  logic       expr_last,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);

	logic [31:0] accum_q;
	logic        in_number_q;
	logic        token_start_q;
	logic        is_digit;
	logic        has_op;
	logic        innum_n;
	logic [31:0] accum_n;
	logic        accept;

	assign in_ready = cmd_ready;
	assign accept   = in_valid & cmd_ready;
	assign is_digit = (char_code >= ChZero) && (char_code <= ChNine);

	always_comb begin
		innum_n = in_number_q;
		accum_n = accum_q;
		has_op  = 1'b0;
		if (token_start_q) begin
			innum_n = is_digit;
			accum_n = {24'd0, char_code - ChZero};
			has_op  = !is_digit;
		end else if (in_number_q) begin
			accum_n = (accum_q << 3) + (accum_q << 1) + {24'd0, char_code} - 32'd48;
		end else begin
			has_op = 1'b1;
		end
		cmd.expr_end = token_last & expr_last;
		if (has_op) begin
			cmd.kind = CMD_OP;
			cmd.data = {24'd0, char_code};
		end else begin
			cmd.kind = (token_last & innum_n) ? CMD_NUM : CMD_NONE;
			cmd.data = accum_n;
		end
	end

	assign cmd_valid = in_valid & ((cmd.kind != CMD_NONE) | cmd.expr_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q       <= '0;
			in_number_q   <= 1'b0;
			token_start_q <= 1'b1;
		end else if (accept) begin
			if (token_last) begin
				accum_q       <= '0;
				in_number_q   <= 1'b0;
				token_start_q <= 1'b1;
			end else begin
				accum_q       <= accum_n;
				in_number_q   <= innum_n;
				token_start_q <= 1'b0;
			end
		end
	end

endmodule

[design/rpn_queue.sv]
// rpn_queue: short command queue between front and back
// depends on rpn_pkg
module rpn_queue import rpn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_data
);

	localparam int Aw = $clog2(QueueDepth);

	cmd_t          mem_q [QueueDepth];
	logic [Aw-1:0] wr_q;
	logic [Aw-1:0] rd_q;
	logic [Aw:0]   cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = cnt_q != (Aw+1)'(QueueDepth);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid & in_ready;
	assign pop       = out_valid & out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == Aw'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == Aw'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
		end
	end

endmodule

[design/rpn_back.sv]
// rpn_back: value stack, operator sequencer, iterative divider and power unit
// depends on rpn_pkg; takes commands from rpn_queue, drives the result register
module rpn_back import rpn_pkg::*; #(
	parameter int STACK_DEPTH = DefStackDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_value,
	output logic [1:0]  out_status
);

	localparam int Aw = $clog2(STACK_DEPTH);
	localparam int Cw = $clog2(STACK_DEPTH + 1);

	localparam logic [3:0] S_FETCH = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_GOT   = 4'd2;
	localparam logic [3:0] S_EXEC  = 4'd3;
	localparam logic [3:0] S_DIV   = 4'd4;
	localparam logic [3:0] S_DFIX  = 4'd5;
	localparam logic [3:0] S_POW   = 4'd6;
	localparam logic [3:0] S_PUSH  = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [31:0]   stack_q [STACK_DEPTH];
	logic [31:0]   rd_data_q;
	logic [3:0]    state_q;
	logic [Cw-1:0] count_q;
	logic [1:0]    err_q;
	logic [7:0]    op_q;
	logic          end_q;
	logic          fin_q;
	logic          second_q;
	logic          from_mem_q;
	logic [31:0]   lhs_q;
	logic [31:0]   rhs_q;
	logic [31:0]   res_q;
	logic [31:0]   base_q;
	logic [31:0]   exp_q;
	logic [31:0]   rem_q;
	logic [31:0]   mag_b_q;
	logic          neg_q;
	logic [4:0]    step_q;
	logic          out_valid_q;
	logic [31:0]   out_value_q;
	logic [1:0]    out_status_q;
	logic [31:0]   popped;
	logic [32:0]   rem_sh;
	logic [32:0]   diff;
	logic          stack_wr;
	logic          stack_rd;

	assign cmd_ready  = state_q == S_FETCH;
	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;
	assign popped     = from_mem_q ? rd_data_q : 32'd0;
	assign rem_sh     = {rem_q, exp_q[31]};
	assign diff       = rem_sh - {1'b0, mag_b_q};
	assign stack_wr   = (state_q == S_PUSH) && (count_q < Cw'(STACK_DEPTH));
	assign stack_rd   = (state_q == S_RD) && (count_q != '0);

	always_ff @(posedge clk) begin
		if (stack_wr) begin
			stack_q[count_q[Aw-1:0]] <= res_q;
		end
		if (stack_rd) begin
			rd_data_q <= stack_q[Aw'(count_q - 1'b1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FETCH;
			count_q     <= '0;
			err_q       <= StOk;
			out_valid_q <= 1'b0;
			end_q       <= 1'b0;
			fin_q       <= 1'b0;
			second_q    <= 1'b0;
			from_mem_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_FETCH: begin
					if (cmd_valid) begin
						op_q     <= cmd.data[7:0];
						res_q    <= cmd.data;
						end_q    <= cmd.expr_end;
						second_q <= 1'b0;
						fin_q    <= 1'b0;
						unique case (cmd.kind)
							CMD_NUM: state_q <= S_PUSH;
							CMD_OP:  state_q <= S_RD;
							default: begin
								fin_q   <= 1'b1;
								state_q <= S_RD;
							end
						endcase
					end
				end
				S_RD: begin
					if (count_q == '0) begin
						from_mem_q <= 1'b0;
						if (err_q == StOk) err_q <= StUnder;
					end else begin
						from_mem_q <= 1'b1;
						count_q    <= count_q - 1'b1;
					end
					state_q <= fin_q ? S_OUT : S_GOT;
				end
				S_GOT: begin
					if (!second_q) begin
						rhs_q    <= popped;
						second_q <= 1'b1;
						state_q  <= S_RD;
					end else begin
						lhs_q   <= popped;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_PUSH;
					unique case (op_q)
						ChPlus:  res_q <= lhs_q + rhs_q;
						ChMinus: res_q <= lhs_q - rhs_q;
						ChStar:  res_q <= lhs_q * rhs_q;
						ChSlash: begin
							if (rhs_q == '0) begin
								res_q <= '0;
								if (err_q == StOk) err_q <= StDivz;
							end else begin
								exp_q   <= lhs_q[31] ? -lhs_q : lhs_q;
								mag_b_q <= rhs_q[31] ? -rhs_q : rhs_q;
								neg_q   <= lhs_q[31] ^ rhs_q[31];
								rem_q   <= '0;
								step_q  <= '0;
								state_q <= S_DIV;
							end
						end
						ChCaret: begin
							if (rhs_q[31]) begin
								if (lhs_q == 32'd1) res_q <= 32'd1;
								else if (lhs_q == '1) res_q <= rhs_q[0] ? '1 : 32'd1;
								else res_q <= '0;
							end else begin
								res_q   <= 32'd1;
								base_q  <= lhs_q;
								exp_q   <= rhs_q;
								step_q  <= '0;
								state_q <= S_POW;
							end
						end
						default: res_q <= '1;
					endcase
				end
				S_DIV: begin
					if (!diff[32]) begin
						rem_q <= diff[31:0];
					end else begin
						rem_q <= rem_sh[31:0];
					end
					exp_q  <= {exp_q[30:0], !diff[32]};
					step_q <= step_q + 1'b1;
					if (step_q == 5'd31) state_q <= S_DFIX;
				end
				S_DFIX: begin
					res_q   <= neg_q ? -exp_q : exp_q;
					state_q <= S_PUSH;
				end
				S_POW: begin
					if (exp_q[0]) res_q <= res_q * base_q;
					base_q <= base_q * base_q;
					exp_q  <= exp_q >> 1;
					step_q <= step_q + 1'b1;
					if (step_q == 5'd30) state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (count_q < Cw'(STACK_DEPTH)) begin
						count_q <= count_q + 1'b1;
					end else if (err_q == StOk) begin
						err_q <= StOver;
					end
					fin_q   <= end_q;
					state_q <= end_q ? S_RD : S_FETCH;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_value_q  <= popped;
						out_status_q <= err_q;
						count_q      <= '0;
						err_q        <= StOk;
						state_q      <= S_FETCH;
					end
				end
				default: state_q <= S_FETCH;
			endcase
		end
	end

endmodule

[design/postfix_expression_evaluator.sv]
// postfix_expression_evaluator: top level of the postfix stack evaluator
// depends on rpn_pkg, rpn_front, rpn_queue, rpn_back
//
// usage
// the slave stream carries one character per word: tdata is the character,
// tlast marks the last character of a token, tuser marks the last token.
// digit-led tokens build a decimal number that is pushed at the token end;
// other tokens apply each character as an operator (+ - * / ^) to two popped
// values. when a word carries both tlast and tuser, the final value is popped
// and one master word carries it with the status, then all state clears.
// the front takes a word per cycle while the four-entry queue has room;
// in the back a number is pushed directly; add/sub/mul pop two values, then
// compute and push; divide uses a 32-step restoring divider, power runs 31
// squaring steps, and the expression end pops the final value. while the
// master side stalls the back holds at its next final pop; the front keeps
// accepting until the queue fills.
// reset clears the stack count, error, queue and the output valid flag.
module postfix_expression_evaluator import rpn_pkg::*; #(
	parameter int STACK_DEPTH = DefStackDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code
	input  logic        s_tlast,   // token_last
	input  logic        s_tuser,   // expr_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // result_value, status, zero pad
);

	logic        f_valid;
	logic        f_ready;
	cmd_t        f_cmd;
	logic        q_valid;
	logic        q_ready;
	cmd_t        q_cmd;
	logic [31:0] value;
	logic [1:0]  status;

	rpn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.char_code  (s_tdata),
		.token_last (s_tlast),
		.expr_last  (s_tuser),
		.cmd_valid  (f_valid),
		.cmd_ready  (f_ready),
		.cmd        (f_cmd)
	);

	rpn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_cmd)
	);

	rpn_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_valid),
		.cmd_ready  (q_ready),
		.cmd        (q_cmd),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (value),
		.out_status (status)
	);

	assign m_tdata = {6'd0, status, value};

endmodule

[design/rpn_checker.sv]
// rpn_checker: port-level assertions for postfix_expression_evaluator
// bound to the top level; no other dependencies
module rpn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// pad bits above status stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:34] == 6'd0)
		else $error("pad bits set");

	// no result word right after reset
	assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result right after reset");

	// stalled result is held
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result dropped");

endmodule

bind postfix_expression_evaluator rpn_checker u_rpn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
